// File: rtl/hmbs_pkg.sv
// Shared types and constants for the heightmap bilinear sampler.
`default_nettype none

package hmbs_pkg;

  // Default largest grid side; storage is MAX_SIDE * MAX_SIDE heights.
  localparam int MAX_SIDE_DEF = 128;

  localparam int HEIGHT_W    = 16;   // signed Q8.8 height
  localparam int POS_W       = 32;   // signed Q16.16 world coordinate
  localparam int SCALE_W     = 32;   // unsigned Q8.24 reciprocal scale
  localparam int SIDE_CFG_W  = 8;    // grid_side register width
  localparam int INDEX_W     = 14;   // write_index width
  localparam int CFG_INDEX_W = 2;    // configuration register index width
  localparam int CFG_DATA_W  = 32;   // widest configuration register
  localparam int PROD_W      = POS_W + SCALE_W;
  localparam int NORM_W      = 40;   // fraction bits of a normalized coordinate
  localparam int WFRAC_W     = 16;   // fraction bits of a cell offset
  localparam int WEIGHT_W    = 2 * WFRAC_W + 1;   // weights reach exactly 1.0
  localparam int TERM_W      = HEIGHT_W + WEIGHT_W;
  localparam int SUM_W       = TERM_W;

  localparam logic [SIDE_CFG_W-1:0] GRID_SIDE_RST = 8'd2;
  localparam logic [SCALE_W-1:0]    INV_SCALE_RST = 32'h0100_0000;
  localparam logic [HEIGHT_W-1:0]   HEIGHT_BIAS   = 16'h8000;
  localparam logic [WFRAC_W:0]      ONE_Q16       = 17'h1_0000;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GRID_SIDE   = 2'd0,
    REG_INV_SCALE_X = 2'd1,
    REG_INV_SCALE_Z = 2'd2
  } cfg_reg_t;

endpackage

`default_nettype wire

// File: rtl/heightmap_bilinear_sampler.sv
// Top level of the heightmap bilinear sampler: a seven-stage pipeline over a banked height grid.
//
// The block accepts one transaction per clock cycle while the output side
// does not stall, with writes and samples mixed freely, and returns results
// in order. The grid lives in two RAM banks split by the parity of the
// row-major index; each bank has one write port and two read ports, so the
// four corners of a cell are fetched in a single cycle. Writes update the RAM
// at the same pipeline stage where samples read it, so every sample sees
// exactly the writes accepted before it. Heights are undefined until written
// and there is no clearing pass after reset. Configuration writes are
// registered; grid_side reaches later stages through side_q and total_q.
`default_nettype none

module heightmap_bilinear_sampler
  import hmbs_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,

  input  logic                        cfg_we,
  input  logic [CFG_INDEX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,

  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        opcode,
  input  logic [INDEX_W-1:0]          write_index,
  input  logic signed [HEIGHT_W-1:0]  height_in,
  input  logic signed [POS_W-1:0]     pos_x,
  input  logic signed [POS_W-1:0]     pos_z,

  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [HEIGHT_W-1:0]  height_out,
  output logic                        out_of_bounds
);

  localparam int DEPTH      = MAX_SIDE * MAX_SIDE;
  localparam int AW         = $clog2(DEPTH);
  localparam int BAW        = AW - 1;
  localparam int BANK_DEPTH = 1 << BAW;
  localparam int SW         = $clog2(MAX_SIDE + 1);
  localparam int IW         = $clog2(MAX_SIDE);
  localparam int TW         = $clog2(DEPTH + 1);
  localparam int CW         = $clog2(DEPTH + MAX_SIDE + 1);
  localparam int EW         = NORM_W + SW;
  localparam int NSTAGE     = 7;

  // Configuration registers.
  logic [SIDE_CFG_W-1:0] grid_side;
  logic [SCALE_W-1:0]    inv_scale_x;
  logic [SCALE_W-1:0]    inv_scale_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side   <= GRID_SIDE_RST;
      inv_scale_x <= INV_SCALE_RST;
      inv_scale_z <= INV_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_SIDE:   grid_side   <= cfg_data[SIDE_CFG_W-1:0];
        REG_INV_SCALE_X: inv_scale_x <= cfg_data[SCALE_W-1:0];
        REG_INV_SCALE_Z: inv_scale_z <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective side and cell count, recomputed every cycle from the register.
  logic [SW-1:0]   side_q;
  logic [TW-1:0]   total_q;
  logic [2*SW-1:0] side_sq;

  assign side_sq = side_q * side_q;

  always_ff @(posedge clk) begin
    if (32'(grid_side) > 32'(MAX_SIDE)) begin
      side_q <= SW'(MAX_SIDE);
    end else begin
      side_q <= SW'(grid_side);
    end
    total_q <= TW'(side_sq);
  end

  // Pipeline flow control: a stage takes new data when it is empty or its
  // contents move on in the same cycle.
  logic [NSTAGE:1] vld;
  logic [NSTAGE:1] rdy;

  always_comb begin
    rdy[NSTAGE] = !vld[NSTAGE] || out_ready;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 1: scale the positions.
  opcode_t              s1_op;
  logic [INDEX_W-1:0]   s1_widx;
  logic [HEIGHT_W-1:0]  s1_hin;
  logic [PROD_W-1:0]    s1_prod_x;
  logic [PROD_W-1:0]    s1_prod_z;
  logic                 s1_neg;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_op     <= opcode_t'(opcode);
      s1_widx   <= write_index;
      s1_hin    <= height_in;
      s1_prod_x <= PROD_W'(pos_x[POS_W-1:0]) * PROD_W'(inv_scale_x);
      s1_prod_z <= PROD_W'(pos_z[POS_W-1:0]) * PROD_W'(inv_scale_z);
      // A negative position is outside unless its scale is zero.
      s1_neg    <= ((inv_scale_x != '0) && pos_x[POS_W-1]) ||
                   ((inv_scale_z != '0) && pos_z[POS_W-1]);
    end
  end

  // Stage 2: bounds check and scale by the grid side.
  opcode_t              s2_op;
  logic [INDEX_W-1:0]   s2_widx;
  logic [HEIGHT_W-1:0]  s2_hin;
  logic                 s2_oob;
  logic [EW-1:0]        s2_er;
  logic [EW-1:0]        s2_ec;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_op   <= s1_op;
      s2_widx <= s1_widx;
      s2_hin  <= s1_hin;
      s2_oob  <= s1_neg || (s1_prod_x[PROD_W-1:NORM_W] != '0) ||
                 (s1_prod_z[PROD_W-1:NORM_W] != '0);
      s2_er   <= EW'(s1_prod_z[NORM_W-1:0]) * EW'(side_q);
      s2_ec   <= EW'(s1_prod_x[NORM_W-1:0]) * EW'(side_q);
    end
  end

  // Stage 3: base corner index and bilinear weights.
  logic [IW-1:0]        s2_row;
  logic [IW-1:0]        s2_col;
  logic [WFRAC_W-1:0]   s2_fr;
  logic [WFRAC_W-1:0]   s2_fc;
  logic [WFRAC_W:0]     s2_fr_inv;
  logic [WFRAC_W:0]     s2_fc_inv;
  logic [IW+SW-1:0]     s2_row_mul;
  logic [2*WFRAC_W+1:0] s2_wa_full;
  logic [2*WFRAC_W+1:0] s2_wb_full;
  logic [2*WFRAC_W+1:0] s2_wc_full;
  logic [2*WFRAC_W+1:0] s2_wd_full;

  assign s2_row     = s2_er[NORM_W +: IW];
  assign s2_col     = s2_ec[NORM_W +: IW];
  assign s2_fr      = s2_er[NORM_W-1 -: WFRAC_W];
  assign s2_fc      = s2_ec[NORM_W-1 -: WFRAC_W];
  assign s2_fr_inv  = ONE_Q16 - {1'b0, s2_fr};
  assign s2_fc_inv  = ONE_Q16 - {1'b0, s2_fc};
  assign s2_row_mul = s2_row * side_q;
  assign s2_wa_full = s2_fr_inv * s2_fc_inv;
  assign s2_wb_full = {1'b0, s2_fr} * s2_fc_inv;
  assign s2_wc_full = s2_fr_inv * {1'b0, s2_fc};
  assign s2_wd_full = {1'b0, s2_fr} * {1'b0, s2_fc};

  opcode_t              s3_op;
  logic [INDEX_W-1:0]   s3_widx;
  logic [HEIGHT_W-1:0]  s3_hin;
  logic                 s3_oob;
  logic [CW-1:0]        s3_base;
  logic [WEIGHT_W-1:0]  s3_wa;
  logic [WEIGHT_W-1:0]  s3_wb;
  logic [WEIGHT_W-1:0]  s3_wc;
  logic [WEIGHT_W-1:0]  s3_wd;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_op   <= s2_op;
      s3_widx <= s2_widx;
      s3_hin  <= s2_hin;
      s3_oob  <= s2_oob;
      s3_base <= CW'(s2_row_mul) + CW'(s2_col);
      s3_wa   <= s2_wa_full[WEIGHT_W-1:0];
      s3_wb   <= s2_wb_full[WEIGHT_W-1:0];
      s3_wc   <= s2_wc_full[WEIGHT_W-1:0];
      s3_wd   <= s2_wd_full[WEIGHT_W-1:0];
    end
  end

  // Stage 4: corner range checks. The right-hand corners are simply the next
  // linear index, which is how the last column wraps onto the next row.
  logic [CW-1:0] s3_ib;
  logic [CW-1:0] s3_base_p1;
  logic [CW-1:0] s3_ib_p1;

  assign s3_ib      = s3_base + CW'(side_q);
  assign s3_base_p1 = s3_base + CW'(1);
  assign s3_ib_p1   = s3_ib + CW'(1);

  opcode_t              s4_op;
  logic [INDEX_W-1:0]   s4_widx;
  logic [HEIGHT_W-1:0]  s4_hin;
  logic                 s4_oob;
  logic [CW-1:0]        s4_base;
  logic [CW-1:0]        s4_ib;
  logic                 s4_b_ok;
  logic                 s4_c_ok;
  logic                 s4_d_ok;
  logic [WEIGHT_W-1:0]  s4_wa;
  logic [WEIGHT_W-1:0]  s4_wb;
  logic [WEIGHT_W-1:0]  s4_wc;
  logic [WEIGHT_W-1:0]  s4_wd;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_op   <= s3_op;
      s4_widx <= s3_widx;
      s4_hin  <= s3_hin;
      s4_oob  <= s3_oob;
      s4_base <= s3_base;
      s4_ib   <= s3_ib;
      s4_b_ok <= s3_ib < CW'(total_q);
      s4_c_ok <= s3_base_p1 < CW'(total_q);
      s4_d_ok <= s3_ib_p1 < CW'(total_q);
      s4_wa   <= s3_wa;
      s4_wb   <= s3_wb;
      s4_wc   <= s3_wc;
      s4_wd   <= s3_wd;
    end
  end

  // Memory access. Each bank sees one index of the base pair and one of the
  // lower pair, since neighbors in linear order differ in parity.
  logic [CW-1:0]       s4_base_p1;
  logic [CW-1:0]       s4_ib_p1;
  logic [AW-1:0]       s4_waddr;
  logic                s4_wr;
  logic                wr_even;
  logic                wr_odd;
  logic [HEIGHT_W-1:0] even_rd0;
  logic [HEIGHT_W-1:0] even_rd1;
  logic [HEIGHT_W-1:0] odd_rd0;
  logic [HEIGHT_W-1:0] odd_rd1;

  assign s4_base_p1 = s4_base + CW'(1);
  assign s4_ib_p1   = s4_ib + CW'(1);
  assign s4_waddr   = AW'(s4_widx);
  assign s4_wr      = vld[4] && rdy[5] && (s4_op == OP_WRITE) &&
                      (32'(s4_widx) < 32'(DEPTH));
  assign wr_even    = s4_wr && !s4_waddr[0];
  assign wr_odd     = s4_wr && s4_waddr[0];

  hmbs_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (BANK_DEPTH)
  ) u_bank_even (
    .clk    (clk),
    .we     (wr_even),
    .waddr  (s4_waddr[BAW:1]),
    .wdata  (s4_hin),
    .re     (rdy[5]),
    .raddr0 (s4_base_p1[BAW:1]),
    .raddr1 (s4_ib_p1[BAW:1]),
    .rdata0 (even_rd0),
    .rdata1 (even_rd1)
  );

  hmbs_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (BANK_DEPTH)
  ) u_bank_odd (
    .clk    (clk),
    .we     (wr_odd),
    .waddr  (s4_waddr[BAW:1]),
    .wdata  (s4_hin),
    .re     (rdy[5]),
    .raddr0 (s4_base[BAW:1]),
    .raddr1 (s4_ib[BAW:1]),
    .rdata0 (odd_rd0),
    .rdata1 (odd_rd1)
  );

  // Stage 5: bank outputs arrive alongside these registers.
  opcode_t              s5_op;
  logic                 s5_oob;
  logic                 s5_base_par;
  logic                 s5_ib_par;
  logic                 s5_b_ok;
  logic                 s5_c_ok;
  logic                 s5_d_ok;
  logic [WEIGHT_W-1:0]  s5_wa;
  logic [WEIGHT_W-1:0]  s5_wb;
  logic [WEIGHT_W-1:0]  s5_wc;
  logic [WEIGHT_W-1:0]  s5_wd;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_op       <= s4_op;
      s5_oob      <= s4_oob;
      s5_base_par <= s4_base[0];
      s5_ib_par   <= s4_ib[0];
      s5_b_ok     <= s4_b_ok;
      s5_c_ok     <= s4_c_ok;
      s5_d_ok     <= s4_d_ok;
      s5_wa       <= s4_wa;
      s5_wb       <= s4_wb;
      s5_wc       <= s4_wc;
      s5_wd       <= s4_wd;
    end
  end

  // Heights are offset by half range so the blend works on unsigned values.
  // A corner past the end of the grid takes the base corner's height.
  logic [HEIGHT_W-1:0] s5_ha;
  logic [HEIGHT_W-1:0] s5_hb;
  logic [HEIGHT_W-1:0] s5_hc;
  logic [HEIGHT_W-1:0] s5_hd;

  always_comb begin
    s5_ha = (s5_base_par ? odd_rd0 : even_rd0) ^ HEIGHT_BIAS;
    s5_hc = (s5_base_par ? even_rd0 : odd_rd0) ^ HEIGHT_BIAS;
    s5_hb = (s5_ib_par ? odd_rd1 : even_rd1) ^ HEIGHT_BIAS;
    s5_hd = (s5_ib_par ? even_rd1 : odd_rd1) ^ HEIGHT_BIAS;
    if (!s5_b_ok) begin
      s5_hb = s5_ha;
    end
    if (!s5_c_ok) begin
      s5_hc = s5_ha;
    end
    if (!s5_d_ok) begin
      s5_hd = s5_ha;
    end
  end

  // Stage 6: weighted corner terms.
  opcode_t            s6_op;
  logic               s6_oob;
  logic [TERM_W-1:0]  s6_pa;
  logic [TERM_W-1:0]  s6_pb;
  logic [TERM_W-1:0]  s6_pc;
  logic [TERM_W-1:0]  s6_pd;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_op  <= s5_op;
      s6_oob <= s5_oob;
      s6_pa  <= TERM_W'(s5_ha) * TERM_W'(s5_wa);
      s6_pb  <= TERM_W'(s5_hb) * TERM_W'(s5_wb);
      s6_pc  <= TERM_W'(s5_hc) * TERM_W'(s5_wc);
      s6_pd  <= TERM_W'(s5_hd) * TERM_W'(s5_wd);
    end
  end

  // Stage 7: sum, round half up, remove the offset; writes and out-of-bounds samples return zero.
  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (2 * WFRAC_W - 1);

  logic [SUM_W-1:0]    s6_sum;
  logic [HEIGHT_W-1:0] s6_height;

  assign s6_sum    = s6_pa + s6_pb + s6_pc + s6_pd + ROUND_HALF;
  assign s6_height = s6_sum[2*WFRAC_W +: HEIGHT_W] ^ HEIGHT_BIAS;

  logic [HEIGHT_W-1:0] s7_height;
  logic                s7_oob;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      if (s6_op == OP_SAMPLE && !s6_oob) begin
        s7_height <= s6_height;
      end else begin
        s7_height <= '0;
      end
      s7_oob <= (s6_op == OP_SAMPLE) && s6_oob;
    end
  end

  assign out_valid     = vld[NSTAGE];
  assign height_out    = s7_height;
  assign out_of_bounds = s7_oob;

endmodule

`default_nettype wire

// File: rtl/hmbs_ram.sv
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module hmbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

`default_nettype wire
